// ----- rtl/i2cbm_pkg.sv -----
package i2cbm_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PhaseW = 5;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_SEND_BYTE = 3'd2,
		CMD_RECV_BYTE = 3'd3,
		CMD_SEND_ACK  = 3'd4,
		CMD_RECV_ACK  = 3'd5
	} cmd_t;

	// One classified tick as it travels from the front part to the back part.
	typedef struct packed {
		logic              start_ok;
		cmd_t              req;
		logic [ByteW-1:0]  tx_byte;
		logic              ack_bit;
		logic              sda_in;
	} tick_item_t;

	// Number of phases in each command sequence.
	function automatic logic [PhaseW-1:0] seq_len(input cmd_t cmd);
		logic [PhaseW-1:0] len;
		unique case (cmd)
			CMD_START:     len = PhaseW'(4);
			CMD_STOP:      len = PhaseW'(3);
			CMD_SEND_BYTE: len = PhaseW'(24);
			CMD_RECV_BYTE: len = PhaseW'(25);
			CMD_SEND_ACK:  len = PhaseW'(3);
			CMD_RECV_ACK:  len = PhaseW'(4);
			default:       len = PhaseW'(4);
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/i2cbm_tick_if.sv -----
interface i2cbm_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] req_type;
	logic [7:0] tx_byte;
	logic       ack_bit;
	logic       sda_in;

	modport source(output valid, cmd_valid, req_type, tx_byte, ack_bit, sda_in, input ready);
	modport sink(input valid, cmd_valid, req_type, tx_byte, ack_bit, sda_in, output ready);
endinterface

// ----- rtl/i2cbm_result_if.sv -----
interface i2cbm_result_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       rx_ack;

	modport source(output valid, scl_level, sda_level, busy_res, done_res, rx_byte, rx_ack,
		input ready);
	modport sink(input valid, scl_level, sda_level, busy_res, done_res, rx_byte, rx_ack,
		output ready);
endinterface

// ----- rtl/i2cbm_front.sv -----
module i2cbm_front import i2cbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	i2cbm_tick_if.sink         tick,
	output logic               push_valid,
	input  logic               push_ready,
	output tick_item_t         push_item
);

	logic       valid_s1;
	tick_item_t item_s1;
	tick_item_t item_d;
	logic       accept;

	assign tick.ready = !valid_s1 || push_ready;
	assign accept     = tick.valid && tick.ready;

	// Request codes beyond the command list never start a sequence.
	always_comb begin
		item_d.req      = cmd_t'(tick.req_type);
		item_d.tx_byte  = tick.tx_byte;
		item_d.ack_bit  = tick.ack_bit;
		item_d.sda_in   = tick.sda_in;
		unique case (tick.req_type)
			CMD_START, CMD_STOP, CMD_SEND_BYTE,
			CMD_RECV_BYTE, CMD_SEND_ACK, CMD_RECV_ACK: begin
				item_d.start_ok = tick.cmd_valid;
			end
			default: begin
				item_d.start_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// ----- rtl/i2cbm_queue.sv -----
module i2cbm_queue import i2cbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  tick_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output tick_item_t pop_item
);

	tick_item_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/i2cbm_back.sv -----
module i2cbm_back import i2cbm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  tick_item_t    pop_item,
	i2cbm_result_if.source result
);

	logic              busy_q;
	cmd_t              cmd_q;
	logic [PhaseW-1:0] phase_q;
	logic [1:0]        mod3_q;
	logic [ByteW-1:0]  tx_q;
	logic [ByteW-1:0]  rx_q;
	logic              scl_q;
	logic              sda_q;
	logic              ack_q;

	logic              out_valid_q;
	logic              out_scl_q;
	logic              out_sda_q;
	logic              out_busy_q;
	logic              out_done_q;
	logic [ByteW-1:0]  out_rx_byte_q;
	logic              out_rx_ack_q;

	logic              pop;
	logic              start;
	logic              run;
	logic              last;
	cmd_t              cmd_e;
	logic [PhaseW-1:0] p_e;
	logic [PhaseW-1:0] p_plus;
	logic [1:0]        m_e;
	logic [1:0]        m_n;
	logic [ByteW-1:0]  tx_e;
	logic [ByteW-1:0]  tx_n;
	logic [ByteW-1:0]  rx_e;
	logic [ByteW-1:0]  rx_n;
	logic              ack_e;
	logic              ack_n;
	logic              scl_n;
	logic              sda_n;
	logic              busy_n;
	logic [PhaseW-1:0] phase_n;
	logic [ByteW-1:0]  rx_byte_n;
	logic              rx_ack_n;

	assign pop_ready = !out_valid_q || result.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		start = pop_item.start_ok && !busy_q;
		run   = busy_q || start;
		cmd_e = start ? pop_item.req : cmd_q;
		p_e   = start ? '0 : phase_q;
		m_e   = start ? 2'd0 : mod3_q;
		tx_e  = (start && pop_item.req == CMD_SEND_BYTE) ? pop_item.tx_byte : tx_q;
		rx_e  = (start && pop_item.req == CMD_RECV_BYTE) ? '0 : rx_q;
		ack_e = (start && pop_item.req == CMD_SEND_ACK) ? pop_item.ack_bit : ack_q;

		tx_n  = tx_e;
		rx_n  = rx_e;
		ack_n = ack_e;
		scl_n = scl_q;
		sda_n = sda_q;

		if (run) begin
			unique case (cmd_e)
				CMD_START: begin
					if (p_e == PhaseW'(0)) sda_n = 1'b1;
					else if (p_e == PhaseW'(1)) scl_n = 1'b1;
					else if (p_e == PhaseW'(2)) sda_n = 1'b0;
					else scl_n = 1'b0;
				end
				CMD_STOP: begin
					if (p_e == PhaseW'(0)) sda_n = 1'b0;
					else if (p_e == PhaseW'(1)) scl_n = 1'b1;
					else sda_n = 1'b1;
				end
				CMD_SEND_BYTE: begin
					// The shift register moves after each clock pulse, so its top bit
					// is the bit driven onto SDA at the start of each bit.
					if (m_e == 2'd0) sda_n = tx_e[ByteW-1];
					else if (m_e == 2'd1) scl_n = 1'b1;
					else begin
						scl_n = 1'b0;
						tx_n  = {tx_e[ByteW-2:0], 1'b0};
					end
				end
				CMD_RECV_BYTE: begin
					if (p_e == PhaseW'(0)) sda_n = 1'b1;
					else if (m_e == 2'd0) scl_n = 1'b1;
					else if (m_e == 2'd1) rx_n = {rx_e[ByteW-2:0], pop_item.sda_in};
					else scl_n = 1'b0;
				end
				CMD_SEND_ACK: begin
					if (p_e == PhaseW'(0)) sda_n = ack_e;
					else if (p_e == PhaseW'(1)) scl_n = 1'b1;
					else scl_n = 1'b0;
				end
				CMD_RECV_ACK: begin
					if (p_e == PhaseW'(0)) sda_n = 1'b1;
					else if (p_e == PhaseW'(1)) scl_n = 1'b1;
					else if (p_e == PhaseW'(2)) ack_n = pop_item.sda_in;
					else scl_n = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// Receive byte spends its first phase releasing SDA, so its three-phase
		// bit cycle starts one phase later than that of send byte.
		if (cmd_e == CMD_RECV_BYTE && p_e == PhaseW'(0)) begin
			m_n = 2'd0;
		end else begin
			m_n = (m_e == 2'd2) ? 2'd0 : m_e + 2'd1;
		end

		p_plus  = p_e + PhaseW'(1);
		last    = run && (p_plus >= seq_len(cmd_e));
		busy_n  = run && !last;
		phase_n = last ? '0 : p_plus;

		rx_byte_n = (last && cmd_e == CMD_RECV_BYTE) ? rx_n : '0;
		rx_ack_n  = last && cmd_e == CMD_RECV_ACK && ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cmd_q       <= CMD_START;
			phase_q     <= '0;
			mod3_q      <= 2'd0;
			tx_q        <= '0;
			rx_q        <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= busy_n;
				cmd_q   <= cmd_e;
				tx_q    <= tx_n;
				rx_q    <= rx_n;
				ack_q   <= ack_n;
				scl_q   <= scl_n;
				sda_q   <= sda_n;
				if (run) begin
					phase_q <= phase_n;
					mod3_q  <= m_n;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_scl_q     <= scl_n;
			out_sda_q     <= sda_n;
			out_busy_q    <= busy_n;
			out_done_q    <= last;
			out_rx_byte_q <= rx_byte_n;
			out_rx_ack_q  <= rx_ack_n;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.scl_level = out_scl_q;
	assign result.sda_level = out_sda_q;
	assign result.busy_res  = out_busy_q;
	assign result.done_res  = out_done_q;
	assign result.rx_byte   = out_rx_byte_q;
	assign result.rx_ack    = out_rx_ack_q;

endmodule

// ----- rtl/i2c_bit_level_master.sv -----
// I2C master bit engine: one phase tick in, one result out, in order.
// Path: each tick passes through the front register, the two-entry queue and the output
// register before its result is valid.
// Throughput: one tick per cycle while result.ready holds; the back part's phase state
// updates once per popped tick. Reset: asynchronous, active low; the engine comes up idle
// with SCL and SDA released and the acknowledge latch at one.
module i2c_bit_level_master import i2cbm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	i2cbm_tick_if.sink      tick,
	i2cbm_result_if.source  result
);

	logic       push_valid;
	logic       push_ready;
	tick_item_t push_item;
	logic       pop_valid;
	logic       pop_ready;
	tick_item_t pop_item;

	i2cbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	i2cbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	i2cbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.result    (result)
	);

endmodule
